// ----- src/psbmk_pkg.sv -----
// Package: shared constants and types for the pair sorter.
`timescale 1ns / 1ps
package psbmk_pkg;

	localparam int MaxPairs  = 64;
	localparam int ValueBits = 32;
	localparam int PortBits  = 32;
	localparam int CntW      = $clog2(MaxPairs + 1);

	typedef logic [ValueBits-1:0] value_t;
	typedef logic [CntW-1:0]      cnt_t;

	typedef struct packed {
		value_t first;
		value_t second;
	} pair_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // an input beat is taken
		logic shift;  // an output beat is taken
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic one_left;  // the head cell holds the final pair of the set
	} dp_sts_t;

	function automatic value_t key_of(input pair_t p);
		return (p.first > p.second) ? p.first : p.second;
	endfunction

endpackage

// ----- src/psbmk_datapath.sv -----
// Datapath: insertion chain of sorted pair cells, fill count and drop flag.
`timescale 1ns / 1ps
module psbmk_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  psbmk_pkg::dp_cmd_t        cmd,
	output psbmk_pkg::dp_sts_t        sts,
	input  logic [psbmk_pkg::PortBits-1:0] first_value,
	input  logic [psbmk_pkg::PortBits-1:0] second_value,
	output logic [psbmk_pkg::PortBits-1:0] first_out,
	output logic [psbmk_pkg::PortBits-1:0] second_out,
	output logic                      end_of_set,
	output logic                      overflow
);

	psbmk_pkg::pair_t  cell_q [psbmk_pkg::MaxPairs];
	psbmk_pkg::cnt_t   cnt_q;
	logic              drop_q;
	psbmk_pkg::pair_t  new_pair;
	psbmk_pkg::value_t new_key;
	logic [psbmk_pkg::MaxPairs-1:0] gt;
	logic              full;
	logic              ins;

	assign new_pair.first  = first_value[psbmk_pkg::ValueBits-1:0];
	assign new_pair.second = second_value[psbmk_pkg::ValueBits-1:0];
	assign new_key  = psbmk_pkg::key_of(new_pair);
	assign full     = (cnt_q == psbmk_pkg::cnt_t'(psbmk_pkg::MaxPairs));
	assign ins      = cmd.load && !full;

	// Each occupied cell compares its key with the incoming one.
	always_comb begin
		for (int i = 0; i < psbmk_pkg::MaxPairs; i++) begin
			gt[i] = (psbmk_pkg::cnt_t'(i) < cnt_q) &&
				(psbmk_pkg::key_of(cell_q[i]) > new_key);
		end
	end

	genvar g;
	generate
		for (g = 0; g < psbmk_pkg::MaxPairs; g++) begin : g_cell
			logic from_below;
			logic take_new;
			psbmk_pkg::pair_t above;

			if (g == 0) begin : g_head
				assign from_below = 1'b0;
			end else begin : g_body
				assign from_below = gt[g-1];
			end

			if (g == psbmk_pkg::MaxPairs - 1) begin : g_tail
				assign above = cell_q[g];
			end else begin : g_mid
				assign above = cell_q[g+1];
			end

			assign take_new = gt[g] || (psbmk_pkg::cnt_t'(g) == cnt_q);

			always_ff @(posedge clk) begin
				if (cmd.shift) begin
					cell_q[g] <= above;
				end else if (ins) begin
					if (from_below) begin
						cell_q[g] <= cell_q[g-((g > 0) ? 1 : 0)];
					end else if (take_new) begin
						cell_q[g] <= new_pair;
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
		end else begin
			if (cmd.shift) begin
				cnt_q <= cnt_q - psbmk_pkg::cnt_t'(1);
				if (sts.one_left) begin
					drop_q <= 1'b0;
				end
			end else if (cmd.load) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + psbmk_pkg::cnt_t'(1);
				end
			end
		end
	end

	assign sts.one_left = (cnt_q == psbmk_pkg::cnt_t'(1));

	assign first_out  = psbmk_pkg::PortBits'(cell_q[0].first);
	assign second_out = psbmk_pkg::PortBits'(cell_q[0].second);
	assign end_of_set = sts.one_left;
	assign overflow   = drop_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= psbmk_pkg::cnt_t'(psbmk_pkg::MaxPairs))
		else $error("fill count beyond store depth");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.shift))
		else $error("load and shift in the same cycle");

	a_shift_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> (cnt_q != '0))
		else $error("shift out of an empty store");

	a_set_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && sts.one_left) |=> (cnt_q == '0) && !drop_q)
		else $error("store not cleared after final beat");

endmodule

// ----- src/psbmk_ctrl.sv -----
// Controller: load and emit phases, handshake control.
`timescale 1ns / 1ps
module psbmk_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               last_pair,
	output logic               out_valid,
	input  logic               out_ready,
	output psbmk_pkg::dp_cmd_t cmd,
	input  psbmk_pkg::dp_sts_t sts
);

	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_EMIT);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.shift = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					// The final pair of a set starts the readout.
					if (cmd.load && last_pair) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.shift && sts.one_left) begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	a_emit_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && last_pair) |=> out_valid && !in_ready)
		else $error("final pair did not start readout");

	a_load_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && !last_pair) |=> in_ready)
		else $error("load phase left without final pair");

	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && sts.one_left) |=> in_ready && !out_valid)
		else $error("readout did not end after final beat");

endmodule

// ----- src/pair_sort_by_max_key_top.sv -----
// Top level: stable sort of value pairs by the larger member of each pair.
//
// Input channel (in_valid / in_ready): one pair per beat, last_pair set on
// the final pair of a set. Pairs are taken one per cycle while loading; each
// beat drops into an insertion chain of 64 cells that compare their keys with
// the new key in parallel, so the store stays sorted at every cycle.
// Output channel (out_valid / out_ready): after the final input beat the
// block emits every stored pair in ascending key order (ties in arrival
// order), one per cycle while out_ready is high, with end_of_set on the last
// beat and overflow on all beats if any pair of the set found the store full.
// The first result is shown in the cycle after the final input beat.
// Input is held off (in_ready low) during the readout, so no new set is taken
// until every stored pair of the previous set has been emitted.
// A stalled receiver holds the head pair; the chain shifts only on a beat.
// Reset clears the fill count, the drop flag and returns to loading; cell
// contents need no reset.
`timescale 1ns / 1ps
module pair_sort_by_max_key_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [psbmk_pkg::PortBits-1:0] first_value,
	input  logic [psbmk_pkg::PortBits-1:0] second_value,
	input  logic                           last_pair,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [psbmk_pkg::PortBits-1:0] first_out,
	output logic [psbmk_pkg::PortBits-1:0] second_out,
	output logic                           end_of_set,
	output logic                           overflow
);

	psbmk_pkg::dp_cmd_t cmd;
	psbmk_pkg::dp_sts_t sts;

	psbmk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last_pair (last_pair),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	psbmk_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.first_value  (first_value),
		.second_value (second_value),
		.first_out    (first_out),
		.second_out   (second_out),
		.end_of_set   (end_of_set),
		.overflow     (overflow)
	);

endmodule

// ----- bench/tb.sv -----
// Testbench for the pair sorter: directed table plus random sets, checked against a local model.
`timescale 1ns / 1ps
module tb;

	localparam int DirectedRows = 21;
	localparam int RandomItems  = 280;
	localparam int LongHold     = 300;
	localparam int IdleLimit    = 2000;
	localparam int DrainCycles  = 8;

	typedef logic [psbmk_pkg::PortBits-1:0] port_t;

	typedef struct packed {
		port_t first;
		port_t second;
		logic  last_beat;
		logic  dropped;
	} exp_beat_t;

	typedef struct packed {
		port_t first;
		port_t second;
		logic  last;
		logic  typed;
		port_t t_first;
		port_t t_second;
		logic  t_last;
		logic  t_ovf;
	} stim_row_t;

	logic  clk          = 1'b0;
	logic  arst_n       = 1'b0;
	logic  in_valid     = 1'b0;
	logic  in_ready;
	port_t first_value  = '0;
	port_t second_value = '0;
	logic  last_pair    = 1'b0;
	logic  out_valid;
	logic  out_ready    = 1'b0;
	port_t first_out;
	port_t second_out;
	logic  end_of_set;
	logic  overflow;

	// Local copy of the sorted store and the drop flag.
	psbmk_pkg::pair_t sort_cells[$];
	bit        cells_dropped = 1'b0;
	exp_beat_t pending_beats[$];
	int        mismatch_count = 0;
	int        idle_cycles = 0;

	// One-pair sets from an empty store come straight back; other rows use the model.
	stim_row_t directed_rows [DirectedRows] = '{
		'{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0},
		'{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0},
		'{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0},
		'{32'd40, 32'd3, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0},
		'{32'd1, 32'd30, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0},
		'{32'd20, 32'd20, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0},
		'{32'd5, 32'd10, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0},
		'{32'd7, 32'd2, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0},
		'{32'd2, 32'd7, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0},
		'{32'd7, 32'd7, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0},
		'{32'd0, 32'd7, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0},
		'{32'h0000_0000, 32'h0000_0001, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0},
		'{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0},
		'{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0},
		'{32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0},
		'{32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0},
		'{32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0},
		'{32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 1'b0}
	};

	pair_sort_by_max_key_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.first_value (first_value),
		.second_value(second_value),
		.last_pair   (last_pair),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.first_out   (first_out),
		.second_out  (second_out),
		.end_of_set  (end_of_set),
		.overflow    (overflow)
	);

	always #4 clk = ~clk;

	function automatic psbmk_pkg::value_t larger_member(input psbmk_pkg::pair_t p);
		return (p.first > p.second) ? p.first : p.second;
	endfunction

	// Mostly no gap, sometimes a few cycles, rarely a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic port_t gen_value(input bit narrow);
		int r;
		r = $urandom_range(0, 9);
		if (narrow)
			return port_t'($urandom_range(0, 7));
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return port_t'($urandom);
	endfunction

	task automatic report_mismatch(input string what, input port_t want, input port_t got);
		$display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
		mismatch_count++;
	endtask

	// Insert after every stored pair with a key not above the new one; emit on the last pair.
	task automatic absorb_pair(input port_t a, input port_t b, input bit last);
		psbmk_pkg::pair_t p;
		int        pos;
		exp_beat_t beat;
		p.first  = psbmk_pkg::value_t'(a);
		p.second = psbmk_pkg::value_t'(b);
		if (sort_cells.size() < psbmk_pkg::MaxPairs) begin
			pos = sort_cells.size();
			while (pos > 0 && larger_member(sort_cells[pos-1]) > larger_member(p))
				pos--;
			sort_cells.insert(pos, p);
		end else begin
			cells_dropped = 1'b1;
		end
		if (last) begin
			for (int i = 0; i < sort_cells.size(); i++) begin
				beat.first     = sort_cells[i].first;
				beat.second    = sort_cells[i].second;
				beat.last_beat = (i == sort_cells.size() - 1);
				beat.dropped   = cells_dropped;
				pending_beats.insert(pending_beats.size(), beat);
			end
			sort_cells.delete();
			cells_dropped = 1'b0;
		end
	endtask

	// Called at a rising edge; returns at a rising edge after the beat and its gap.
	task automatic send_pair(input port_t a, input port_t b, input bit last,
			input bit typed, input exp_beat_t typed_beat);
		int gap;
		in_valid     <= 1'b1;
		first_value  <= a;
		second_value <= b;
		last_pair    <= last;
		do
			@(posedge clk);
		while (!in_ready);
		if (typed)
			pending_beats.insert(pending_beats.size(), typed_beat);
		else
			absorb_pair(a, b, last);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		exp_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_beats.size() == 0) begin
				report_mismatch("unexpected beat, first_out", '0, first_out);
			end else begin
				want = pending_beats.pop_front();
				if (first_out !== want.first)
					report_mismatch("first_out", want.first, first_out);
				if (second_out !== want.second)
					report_mismatch("second_out", want.second, second_out);
				if (end_of_set !== want.last_beat)
					report_mismatch("end_of_set", port_t'(want.last_beat), port_t'(end_of_set));
				if (overflow !== want.dropped)
					report_mismatch("overflow", port_t'(want.dropped), port_t'(overflow));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		if (idle_cycles >= IdleLimit) begin
			$display("tb failed");
			$finish;
		end
	end

	// Receiver: one long hold right after reset and another later on, random gaps otherwise.
	initial begin
		int  run;
		int  gap;
		int  beats;
		bit  held_again;
		beats      = 0;
		held_again = 1'b0;
		wait (arst_n);
		@(posedge clk);
		repeat (LongHold) @(posedge clk);
		forever begin
			out_ready <= 1'b1;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
			repeat (run) begin
				@(posedge clk);
				if (out_valid && out_ready)
					beats++;
			end
			if (!held_again && beats >= 100) begin
				held_again = 1'b1;
				gap = LongHold;
			end else begin
				gap = pick_gap();
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		exp_beat_t typed_beat;
		int        set_len;
		int        set_no;
		int        random_sent;
		int        r;
		bit        narrow;
		set_no      = 0;
		random_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int row = 0; row < DirectedRows; row++) begin
			typed_beat.first     = directed_rows[row].t_first;
			typed_beat.second    = directed_rows[row].t_second;
			typed_beat.last_beat = directed_rows[row].t_last;
			typed_beat.dropped   = directed_rows[row].t_ovf;
			send_pair(directed_rows[row].first, directed_rows[row].second,
				directed_rows[row].last, directed_rows[row].typed, typed_beat);
		end

		typed_beat = '0;
		while (random_sent < RandomItems) begin
			// Start with a full store, then a dropped final pair, then a few drops.
			case (set_no)
				0: set_len = psbmk_pkg::MaxPairs;
				1: set_len = psbmk_pkg::MaxPairs + 1;
				2: set_len = psbmk_pkg::MaxPairs + 3;
				default: begin
					r = $urandom_range(0, 99);
					if (r < 70)
						set_len = $urandom_range(1, 8);
					else if (r < 92)
						set_len = $urandom_range(9, 30);
					else
						set_len = $urandom_range(psbmk_pkg::MaxPairs - 4,
							psbmk_pkg::MaxPairs + 6);
				end
			endcase
			// Narrow values force many equal keys.
			narrow = ($urandom_range(0, 2) == 0);
			for (int k = 0; k < set_len; k++)
				send_pair(gen_value(narrow), gen_value(narrow), k == set_len - 1, 1'b0, typed_beat);
			random_sent += set_len;
			set_no++;
		end
		in_valid <= 1'b0;

		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
